// ===== hw/rtl/lc3_instruction_core_defines.svh =====
// Assertion macros shared by the LC-3 core RTL.
`ifndef LC3_INSTRUCTION_CORE_DEFINES_SVH
`define LC3_INSTRUCTION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LC3_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LC3_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define LC3_ASSERT(label, prop, msg)
`define LC3_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== hw/rtl/lc3_pkg.sv =====
// ----------------------------------------------------------------------------
// lc3_pkg
// Types and codes shared by the LC-3 instruction core.
// ----------------------------------------------------------------------------
package lc3_pkg;
	localparam logic [1:0] CMD_MEM_WR = 2'd0;
	localparam logic [1:0] CMD_MEM_RD = 2'd1;
	localparam logic [1:0] CMD_REG_WR = 2'd2;
	localparam logic [1:0] CMD_STEP   = 2'd3;

	localparam logic [3:0] REG_PC   = 4'd8;
	localparam logic [3:0] REG_COND = 4'd9;

	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LD   = 4'd2;
	localparam logic [3:0] OP_ST   = 4'd3;
	localparam logic [3:0] OP_JSR  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDR  = 4'd6;
	localparam logic [3:0] OP_STR  = 4'd7;
	localparam logic [3:0] OP_RTI  = 4'd8;
	localparam logic [3:0] OP_NOT  = 4'd9;
	localparam logic [3:0] OP_LDI  = 4'd10;
	localparam logic [3:0] OP_STI  = 4'd11;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_RES  = 4'd13;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [2:0] FLAG_N = 3'b100;
	localparam logic [2:0] FLAG_Z = 3'b010;
	localparam logic [2:0] FLAG_P = 3'b001;

	localparam logic [7:0] TRAP_LO = 8'h20;
	localparam logic [7:0] TRAP_HI = 8'h23;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] address;
		logic [15:0] data;
		logic [3:0]  reg_index;
	} lc3_req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [15:0] pc_after;
		logic [2:0]  cond_flags;
		logic [15:0] executed_instruction;
		logic        trap_taken;
		logic [7:0]  trap_vector;
		logic        stopped;
		logic        reg_write_valid;
		logic [2:0]  reg_write_index;
		logic [15:0] reg_write_value;
	} lc3_rsp_t;

	function automatic logic [15:0] sext9(input logic [15:0] v);
		return {{7{v[8]}}, v[8:0]};
	endfunction
	function automatic logic [15:0] sext11(input logic [15:0] v);
		return {{5{v[10]}}, v[10:0]};
	endfunction
	function automatic logic [15:0] sext6(input logic [15:0] v);
		return {{10{v[5]}}, v[5:0]};
	endfunction
	function automatic logic [15:0] sext5(input logic [15:0] v);
		return {{11{v[4]}}, v[4:0]};
	endfunction
	function automatic logic [2:0] nzp(input logic [15:0] v);
		if (v == 16'd0) return FLAG_Z;
		else if (v[15]) return FLAG_N;
		else return FLAG_P;
	endfunction
endpackage

// ===== hw/rtl/lc3_ram.sv =====
// ----------------------------------------------------------------------------
// lc3_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lc3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one word
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) mem[addr] <= wdata;
			else rdata <= mem[addr];
		end
	end
endmodule

// ===== hw/rtl/lc3_regfile.sv =====
// ----------------------------------------------------------------------------
// lc3_regfile
// Eight general registers, two combinational read ports, one write port.
// ----------------------------------------------------------------------------
module lc3_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [2:0]  waddr,
	input  logic [15:0] wdata,
	input  logic [2:0]  raddr_a,
	input  logic [2:0]  raddr_b,
	output logic [15:0] rdata_a,
	output logic [15:0] rdata_b
);
	logic [15:0] regs_q [8];

	// update one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) regs_q[i] <= '0;
		end else if (we) begin
			regs_q[waddr] <= wdata;
		end
	end

	assign rdata_a = regs_q[raddr_a];
	assign rdata_b = regs_q[raddr_b];
endmodule

// ===== hw/rtl/lc3_instruction_core.sv =====
// ----------------------------------------------------------------------------
// lc3_instruction_core
// LC-3 core with private word memory, driven by host requests.
// ----------------------------------------------------------------------------
// Usage: the host sends requests on req (valid/ready): memory write, memory
// read, register write (R0-R7, PC, flags) or one instruction step. Each request
// yields exactly one response on rsp (valid/ready) with PC, flags, stop mark
// and what the step did. The core works on one request at a time.
// A register write, memory write, memory read or a step while stopped passes
// through EXEC to RESP; a step passes FETCH and DECODE, then MEM1 for
// LD/LDR/ST/STR or MEM1 and MEM2 for LDI/STI, before RESP. The next request
// is taken the cycle after the response is accepted. Memory accesses go
// through the single port of the word memory. Reset clears R0-R7, PC, flags
// and the stop mark; memory content is undefined until written. While the
// receiver stalls, the response is held and no new request is taken.
// ----------------------------------------------------------------------------
`include "lc3_instruction_core_defines.svh"
module lc3_instruction_core import lc3_pkg::*; #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  lc3_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output lc3_rsp_t rsp
);
	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_FETCH, S_DECODE, S_MEM1, S_MEM2, S_RESP
	} state_t;

	state_t      state_q;
	lc3_req_t    req_q;
	logic [15:0] pc_q, ir_q;
	logic [2:0]  cc_q;
	logic        halt_q;
	lc3_rsp_t    rsp_q;

	logic [MEM_ADDR_BITS-1:0] mem_addr;
	logic        mem_en, mem_we;
	logic [15:0] mem_wdata, mem_rdata;

	logic        rf_we;
	logic [2:0]  rf_waddr, rf_ra, rf_rb;
	logic [15:0] rf_wdata, rf_a, rf_b;

	lc3_ram #(.WIDTH(16), .DEPTH(1 << MEM_ADDR_BITS)) u_mem (
		.clk(clk), .en(mem_en), .we(mem_we), .addr(mem_addr),
		.wdata(mem_wdata), .rdata(mem_rdata)
	);

	lc3_regfile u_rf (
		.clk(clk), .arst_n(arst_n), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr_a(rf_ra), .raddr_b(rf_rb), .rdata_a(rf_a), .rdata_b(rf_b)
	);

	logic [3:0]  op;
	logic [15:0] pc1, off9, base_ea;
	assign op      = mem_rdata[15:12];
	assign pc1     = pc_q + 16'd1;
	assign off9    = pc1 + sext9(mem_rdata);
	assign base_ea = rf_a + sext6(mem_rdata);

	// register file ports: decode reads from the fetched word, later stages from ir
	always_comb begin
		if (state_q == S_DECODE) begin
			rf_ra = mem_rdata[8:6];
			rf_rb = (op == OP_ADD || op == OP_AND) ? mem_rdata[2:0] : mem_rdata[11:9];
		end else begin
			rf_ra = ir_q[8:6];
			rf_rb = ir_q[11:9];
		end
	end

	// memory port control
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = rf_b;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && (req.command == CMD_MEM_WR || req.command == CMD_MEM_RD)) begin
					mem_en    = 1'b1;
					mem_we    = (req.command == CMD_MEM_WR);
					mem_addr  = req.address[MEM_ADDR_BITS-1:0];
					mem_wdata = req.data;
				end else if (req_valid && req.command == CMD_STEP && !halt_q) begin
					mem_en   = 1'b1;
					mem_addr = pc_q[MEM_ADDR_BITS-1:0];
				end
			end
			S_DECODE: begin
				priority case (op)
					OP_LD, OP_LDI, OP_ST: begin
						mem_en   = 1'b1;
						mem_we   = (op == OP_ST);
						mem_addr = off9[MEM_ADDR_BITS-1:0];
					end
					OP_STI: begin
						mem_en   = 1'b1;
						mem_addr = off9[MEM_ADDR_BITS-1:0];
					end
					OP_LDR, OP_STR: begin
						mem_en   = 1'b1;
						mem_we   = (op == OP_STR);
						mem_addr = base_ea[MEM_ADDR_BITS-1:0];
					end
					default: ;
				endcase
			end
			S_MEM1: begin
				if (ir_q[15:12] == OP_LDI || ir_q[15:12] == OP_STI) begin
					mem_en   = 1'b1;
					mem_we   = (ir_q[15:12] == OP_STI);
					mem_addr = mem_rdata[MEM_ADDR_BITS-1:0];
				end
			end
			default: ;
		endcase
	end

	// register write for load results in the memory stages
	logic        ld_done;
	logic [15:0] rb_val;
	assign ld_done = (state_q == S_MEM1 && (ir_q[15:12] == OP_LD || ir_q[15:12] == OP_LDR))
		|| (state_q == S_MEM2 && ir_q[15:12] == OP_LDI);
	assign rb_val = mem_rdata[5] ? sext5(mem_rdata) : rf_b;

	logic        dec_wr, dec_flags;
	logic [2:0]  dec_dr;
	logic [15:0] dec_res, dec_pc;
	logic        dec_halt;

	// execute register, branch, jump and trap instructions on the fetched word
	always_comb begin
		dec_wr = 1'b0; dec_flags = 1'b0; dec_dr = mem_rdata[11:9];
		dec_res = '0; dec_pc = pc1; dec_halt = 1'b0;
		unique case (op)
			OP_BR:  if ((mem_rdata[11:9] & cc_q) != 3'd0) dec_pc = off9;
			OP_ADD: begin dec_res = rf_a + rb_val; dec_wr = 1'b1; dec_flags = 1'b1; end
			OP_AND: begin dec_res = rf_a & rb_val; dec_wr = 1'b1; dec_flags = 1'b1; end
			OP_NOT: begin dec_res = ~rf_a; dec_wr = 1'b1; dec_flags = 1'b1; end
			OP_LEA: begin dec_res = off9; dec_wr = 1'b1; dec_flags = 1'b1; end
			OP_JMP: dec_pc = rf_a;
			OP_JSR: begin
				dec_res = pc1; dec_dr = 3'd7; dec_wr = 1'b1;
				dec_pc  = mem_rdata[11] ? pc1 + sext11(mem_rdata) : rf_a;
			end
			OP_TRAP: begin
				dec_res = pc1; dec_dr = 3'd7; dec_wr = 1'b1;
				dec_halt = (mem_rdata[7:0] < TRAP_LO) || (mem_rdata[7:0] > TRAP_HI);
			end
			default: ;
		endcase
	end

	always_comb begin
		rf_we = 1'b0; rf_waddr = ir_q[11:9]; rf_wdata = mem_rdata;
		if (state_q == S_IDLE && req_valid && req.command == CMD_REG_WR
			&& req.reg_index < REG_PC) begin
			rf_we = 1'b1; rf_waddr = req.reg_index[2:0]; rf_wdata = req.data;
		end else if (state_q == S_DECODE) begin
			rf_we = dec_wr; rf_waddr = dec_dr; rf_wdata = dec_res;
		end else if (ld_done) begin
			rf_we = 1'b1;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP);
	assign rsp       = rsp_q;

	// sequencer: hold state, pc, flags, stop mark and response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			cc_q    <= '0;
			halt_q  <= 1'b0;
			req_q   <= '0;
			ir_q    <= '0;
			rsp_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						rsp_q <= '0;
						if (req.command == CMD_REG_WR) begin
							if (req.reg_index == REG_PC) begin
								pc_q <= req.data; halt_q <= 1'b0;
							end else if (req.reg_index == REG_COND) begin
								cc_q <= req.data[2:0];
							end
						end
						if (req.command == CMD_STEP && !halt_q) state_q <= S_FETCH;
						else state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					rsp_q.pc_after   <= pc_q;
					rsp_q.cond_flags <= cc_q;
					rsp_q.stopped    <= halt_q;
					if (req_q.command == CMD_MEM_RD) rsp_q.read_data <= mem_rdata;
					state_q <= S_RESP;
				end
				S_FETCH: state_q <= S_DECODE;
				S_DECODE: begin
					ir_q <= mem_rdata;
					rsp_q.executed_instruction <= mem_rdata;
					if (op == OP_TRAP) begin
						rsp_q.trap_taken  <= 1'b1;
						rsp_q.trap_vector <= mem_rdata[7:0];
					end
					rsp_q.reg_write_valid <= dec_wr;
					rsp_q.reg_write_index <= dec_wr ? dec_dr : 3'd0;
					rsp_q.reg_write_value <= dec_res;
					if (op == OP_LD || op == OP_LDI || op == OP_ST || op == OP_STI
						|| op == OP_LDR || op == OP_STR) begin
						pc_q    <= pc1;
						state_q <= S_MEM1;
					end else begin
						pc_q   <= dec_pc;
						halt_q <= halt_q | dec_halt;
						if (dec_flags) cc_q <= nzp(dec_res);
						rsp_q.pc_after   <= dec_pc;
						rsp_q.cond_flags <= dec_flags ? nzp(dec_res) : cc_q;
						rsp_q.stopped    <= halt_q | dec_halt;
						state_q <= S_RESP;
					end
				end
				S_MEM1, S_MEM2: begin
					if (state_q == S_MEM1 && (ir_q[15:12] == OP_LDI || ir_q[15:12] == OP_STI)) begin
						state_q <= S_MEM2;
					end else begin
						if (ld_done) begin
							cc_q <= nzp(mem_rdata);
							rsp_q.reg_write_valid <= 1'b1;
							rsp_q.reg_write_index <= ir_q[11:9];
							rsp_q.reg_write_value <= mem_rdata;
						end
						rsp_q.cond_flags <= ld_done ? nzp(mem_rdata) : cc_q;
						rsp_q.pc_after   <= pc_q;
						rsp_q.stopped    <= halt_q;
						state_q <= S_RESP;
					end
				end
				S_RESP: if (rsp_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`LC3_ASSERT(a_one_side, !(req_ready && rsp_valid), "request and response sides both open")
	`LC3_ASSERT_NEXT(a_take, req_valid && req_ready, !req_ready, "idle after taking a request")
	`LC3_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response dropped")
	`LC3_ASSERT(a_nonstep, !(rsp_valid && req_q.command != CMD_STEP && (rsp.trap_taken || rsp.reg_write_valid)), "step fields set on non-step")
endmodule

// ===== bench/tb_lc3_instruction_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lc3_instruction_core
// Self-checking bench for the LC-3 core: an in-bench model of the machine
// predicts one response per request. Memory words are written before any
// fetch or load can touch them. Directed programs cover every opcode, then
// random programs run under three idling mixes and one long receiver stall.
// ----------------------------------------------------------------------------
module tb_lc3_instruction_core;
	import lc3_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	lc3_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	lc3_rsp_t rsp;

	// machine state as the bench sees it
	logic [15:0] gpr [8];
	logic [15:0] pc_q;
	logic [2:0]  flags_q;
	logic        halted_q;
	logic [15:0] mem [65536];
	bit          mem_known [65536];
	logic [15:0] known_addrs [$];

	lc3_rsp_t expected_q [$];
	int       error_count = 0;
	int       tx_idle_pct = 0;
	int       rx_idle_pct = 0;
	bit       hold_go = 1'b0;
	bit       hold_on = 1'b0;

	lc3_instruction_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
		logic [15:0] m;
		m = 16'hFFFF >> (16 - bits);
		return v[bits-1] ? (v | ~m) : (v & m);
	endfunction

	function automatic logic [2:0] flags_of(input logic [15:0] v);
		if (v == 16'd0) return FLAG_Z;
		if (v[15]) return FLAG_N;
		return FLAG_P;
	endfunction

	function automatic void mem_store(input logic [15:0] a, input logic [15:0] v);
		if (!mem_known[a]) known_addrs.push_back(a);
		mem_known[a] = 1'b1;
		mem[a] = v;
	endfunction

	// Advance the machine by one request and return the response it owes.
	function automatic lc3_rsp_t run_machine(input lc3_req_t r);
		lc3_rsp_t o;
		logic [15:0] ins, npc, res, b;
		logic [3:0] op;
		logic [2:0] dr, sr1;
		bit wr, upd;
		o = '0;
		if (r.command == CMD_MEM_WR) begin
			mem_store(r.address, r.data);
		end else if (r.command == CMD_MEM_RD) begin
			o.read_data = mem[r.address];
		end else if (r.command == CMD_REG_WR) begin
			if (r.reg_index < 4'd8) gpr[r.reg_index[2:0]] = r.data;
			else if (r.reg_index == REG_PC) begin
				pc_q = r.data;
				halted_q = 1'b0;
			end else if (r.reg_index == REG_COND) flags_q = r.data[2:0];
		end else if (!halted_q) begin
			ins = mem[pc_q];
			npc = pc_q + 16'd1;
			op = ins[15:12];
			dr = ins[11:9];
			sr1 = ins[8:6];
			res = '0;
			wr = 0;
			upd = 0;
			case (op)
				OP_BR: if ((dr & flags_q) != 3'd0) npc = npc + sx(ins, 9);
				OP_ADD, OP_AND: begin
					b = ins[5] ? sx(ins, 5) : gpr[ins[2:0]];
					res = (op == OP_ADD) ? gpr[sr1] + b : gpr[sr1] & b;
					wr = 1; upd = 1;
				end
				OP_LD: begin res = mem[npc + sx(ins, 9)]; wr = 1; upd = 1; end
				OP_ST: mem_store(npc + sx(ins, 9), gpr[dr]);
				OP_JSR: begin
					res = npc;
					npc = ins[11] ? npc + sx(ins, 11) : gpr[sr1];
					dr = 3'd7; wr = 1;
				end
				OP_LDR: begin res = mem[gpr[sr1] + sx(ins, 6)]; wr = 1; upd = 1; end
				OP_STR: mem_store(gpr[sr1] + sx(ins, 6), gpr[dr]);
				OP_NOT: begin res = ~gpr[sr1]; wr = 1; upd = 1; end
				OP_LDI: begin res = mem[mem[npc + sx(ins, 9)]]; wr = 1; upd = 1; end
				OP_STI: mem_store(mem[npc + sx(ins, 9)], gpr[dr]);
				OP_JMP: npc = gpr[sr1];
				OP_LEA: begin res = npc + sx(ins, 9); wr = 1; upd = 1; end
				OP_TRAP: begin
					o.trap_taken = 1'b1;
					o.trap_vector = ins[7:0];
					res = npc; dr = 3'd7; wr = 1;
					if (ins[7:0] < TRAP_LO || ins[7:0] > TRAP_HI) halted_q = 1'b1;
				end
				default: ;
			endcase
			if (wr) begin
				gpr[dr] = res;
				o.reg_write_valid = 1'b1;
				o.reg_write_index = dr;
				o.reg_write_value = res;
				if (upd) flags_q = flags_of(res);
			end
			pc_q = npc;
			o.executed_instruction = ins;
		end
		o.pc_after = pc_q;
		o.cond_flags = flags_q;
		o.stopped = halted_q;
		return o;
	endfunction

	// Predict, then offer one request and hold it until accepted.
	task automatic send_request(input lc3_req_t r);
		int gap;
		expected_q.push_back(run_machine(r));
		if ($urandom_range(99) < tx_idle_pct) begin
			gap = $urandom_range(1, 4);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic send_cmd(input logic [1:0] c, input logic [15:0] a,
			input logic [15:0] d, input logic [3:0] ri);
		lc3_req_t r;
		r.command = c;
		r.address = a;
		r.data = d;
		r.reg_index = ri;
		send_request(r);
	endtask

	task automatic make_known(input logic [15:0] a, input logic [15:0] v);
		if (!mem_known[a]) send_cmd(CMD_MEM_WR, a, v, 4'($urandom_range(15)));
	endtask

	function automatic logic [15:0] random_instruction();
		logic [15:0] w;
		w = 16'($urandom);
		if (w[15:12] == OP_TRAP) begin
			w[11:8] = 4'd0;
			if ($urandom_range(9) < 8) w[7:0] = 8'(TRAP_LO + $urandom_range(3));
		end
		return w;
	endfunction

	// Write every word that the next step will read, then step.
	task automatic do_step();
		logic [15:0] ins, npc, ea;
		if (!halted_q) begin
			make_known(pc_q, random_instruction());
			ins = mem[pc_q];
			npc = pc_q + 16'd1;
			case (ins[15:12])
				OP_LD, OP_STI: make_known(npc + sx(ins, 9), 16'($urandom));
				OP_LDR: make_known(gpr[ins[8:6]] + sx(ins, 6), 16'($urandom));
				OP_LDI: begin
					ea = npc + sx(ins, 9);
					make_known(ea, 16'($urandom));
					make_known(mem[ea], 16'($urandom));
				end
				default: ;
			endcase
		end
		send_cmd(CMD_STEP, 16'($urandom), 16'($urandom), 4'($urandom_range(15)));
	endtask

	task automatic run_instruction(input logic [15:0] ins);
		if (!halted_q) send_cmd(CMD_MEM_WR, pc_q, ins, 4'd0);
		do_step();
	endtask

	// Drop the request line and wait until every response is back.
	task automatic drain();
		int guard;
		guard = 0;
		req_valid <= 1'b0;
		while (expected_q.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("tb: %s mismatch at %0t: got %h, expected %h", what, $realtime, got, want);
		error_count++;
	endtask

	// Receiver: random stalls, forced low during a hold-off.
	always @(negedge clk)
		rsp_ready <= !hold_on && ($urandom_range(99) >= rx_idle_pct);

	// Hold the receiver off for a long stretch once asked.
	initial begin
		wait (hold_go);
		@(negedge clk);
		hold_on = 1'b1;
		repeat (300) @(negedge clk);
		hold_on = 1'b0;
	end

	// Compare each accepted response with the oldest prediction.
	always @(posedge clk) begin
		lc3_rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected response", rsp.pc_after, 16'd0);
			end else begin
				e = expected_q.pop_front();
				if (rsp.read_data !== e.read_data)
					report_mismatch("read_data", rsp.read_data, e.read_data);
				if (rsp.pc_after !== e.pc_after)
					report_mismatch("pc_after", rsp.pc_after, e.pc_after);
				if (rsp.cond_flags !== e.cond_flags)
					report_mismatch("cond_flags", rsp.cond_flags, e.cond_flags);
				if (rsp.executed_instruction !== e.executed_instruction)
					report_mismatch("executed_instruction", rsp.executed_instruction,
						e.executed_instruction);
				if (rsp.trap_taken !== e.trap_taken)
					report_mismatch("trap_taken", rsp.trap_taken, e.trap_taken);
				if (rsp.trap_vector !== e.trap_vector)
					report_mismatch("trap_vector", rsp.trap_vector, e.trap_vector);
				if (rsp.stopped !== e.stopped)
					report_mismatch("stopped", rsp.stopped, e.stopped);
				if (rsp.reg_write_valid !== e.reg_write_valid)
					report_mismatch("reg_write_valid", rsp.reg_write_valid, e.reg_write_valid);
				if (rsp.reg_write_index !== e.reg_write_index)
					report_mismatch("reg_write_index", rsp.reg_write_index, e.reg_write_index);
				if (rsp.reg_write_value !== e.reg_write_value)
					report_mismatch("reg_write_value", rsp.reg_write_value, e.reg_write_value);
			end
		end
	end

	// Register writes, memory extremes and one pass over every opcode.
	task automatic test_directed();
		send_cmd(CMD_MEM_WR, 16'h0000, 16'hFFFF, 4'd0);
		send_cmd(CMD_MEM_WR, 16'hFFFF, 16'h0000, 4'd15);
		send_cmd(CMD_MEM_RD, 16'hFFFF, 16'hFFFF, 4'd0);
		send_cmd(CMD_MEM_RD, 16'h0000, 16'h0000, 4'd0);
		send_cmd(CMD_REG_WR, 16'h0000, 16'h7FFF, 4'd0);
		send_cmd(CMD_REG_WR, 16'h0000, 16'hFFFF, REG_COND);
		send_cmd(CMD_REG_WR, 16'h0000, 16'h1234, 4'd12);
		send_cmd(CMD_REG_WR, 16'hFFFF, 16'h3000, REG_PC);
		run_instruction(16'h1230); // ADD imm
		run_instruction(16'h1441); // ADD reg
		run_instruction(16'h56AF); // AND imm
		run_instruction(16'h98FF); // NOT
		run_instruction(16'h2B00); // LD, most negative offset
		run_instruction(16'h34FF); // ST, largest offset
		run_instruction(16'hAC03); // LDI
		run_instruction(16'hB204); // STI
		run_instruction(16'h60A0); // LDR
		run_instruction(16'h781F); // STR
		run_instruction(16'hEE05); // LEA
		run_instruction(16'h0000); // BR never
		run_instruction(16'h0E01); // BR always
		run_instruction(16'h8000); // RTI slot does nothing
		run_instruction(16'hD000); // reserved opcode
		run_instruction(16'h4802); // JSR
		run_instruction(16'h41C0); // JSRR through R7 jumps to old R7
		run_instruction(16'hC1C0); // JMP
		run_instruction(16'hF021); // TRAP that keeps running
		run_instruction(16'hF025); // halt
		do_step();                 // step while stopped
		send_cmd(CMD_REG_WR, 16'h0000, 16'h3000, REG_PC);
		drain();
	endtask

	// Random programs with some noise around them.
	task automatic run_random(input int count);
		int k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (halted_q && k < 40)
				send_cmd(CMD_REG_WR, 16'($urandom), 16'(16'h3000 + $urandom_range(255)),
					REG_PC);
			else if (k < 72)
				do_step();
			else if (k < 80)
				send_cmd(CMD_MEM_WR, 16'($urandom), 16'($urandom), 4'($urandom_range(15)));
			else if (k < 88)
				send_cmd(CMD_MEM_RD, known_addrs[$urandom_range(known_addrs.size() - 1)],
					16'($urandom), 4'($urandom_range(15)));
			else if (k < 92)
				send_cmd(CMD_REG_WR, 16'($urandom), 16'(16'h3000 + $urandom_range(255)),
					REG_PC);
			else
				send_cmd(CMD_REG_WR, 16'($urandom), 16'($urandom), 4'($urandom_range(15)));
		end
	endtask

	task automatic test_random();
		tx_idle_pct = 34; rx_idle_pct = 62;
		run_random(160);
		drain();
		tx_idle_pct = 62; rx_idle_pct = 34;
		run_random(160);
		drain();
		tx_idle_pct = 0; rx_idle_pct = 0;
		run_random(160);
		drain();
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0; rx_idle_pct = 10;
		hold_go = 1'b1;
		run_random(80);
		drain();
	endtask

	initial begin
		for (int i = 0; i < 8; i++) gpr[i] = '0;
		pc_q = '0;
		flags_q = '0;
		halted_q = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		test_backpressure();
		drain();
		if (error_count == 0 && expected_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end
endmodule
